// ----- rtl/core/scbs_pkg.sv -----
// shared types and constants for the stereo clip and boxcar smoother
package scbs_pkg;

  localparam int GAIN_W     = 9;
  localparam int TONE_W     = 5;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TONE = 1'b1;

  // 0.95 as 31130 / 2^15
  localparam logic signed [15:0] SCALE_NUM   = 16'sd31130;
  localparam int                 SCALE_SHIFT = 15;

  localparam logic [TONE_W-1:0] TONE_RESET = 5'd1;

  typedef struct packed {
    logic capture;
    logic mul;
    logic scale;
    logic ring_wr;
    logic sum_clr;
    logic sum_rd;
    logic div_load;
    logic div_step;
    logic out_load;
  } scbs_cmd_t;

  typedef struct packed {
    logic bypass;
    logic rd_last;
    logic div_last;
    logic out_free;
  } scbs_sts_t;

endpackage

// ----- rtl/core/scbs_if.sv -----
// stream interfaces for the frame input and result channels
interface scbs_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          block_last;

  modport source (output valid, output left_sample, output right_sample,
                  output block_last, input ready);
  modport sink (input valid, input left_sample, input right_sample,
                input block_last, output ready);
endinterface

interface scbs_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          block_last_out;

  modport source (output valid, output left_out, output right_out,
                  output block_last_out, input ready);
  modport sink (input valid, input left_out, input right_out,
                input block_last_out, output ready);
endinterface

// ----- rtl/core/scbs_div.sv -----
// bit-serial signed divider, quotient truncated toward zero
module scbs_div #(
  parameter int W  = 30,
  parameter int DW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                step,
  input  logic signed [W-1:0] dividend,
  input  logic [DW-1:0]       divisor,
  output logic signed [W-1:0] quotient,
  output logic                last
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] d_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   shifted;
  logic [DW+1:0] trial;

  assign shifted = {rem_r, quo_r[W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, d_r};
  assign last    = (cnt_r == CW'(W - 1));

  always_comb begin
    if (!trial[DW+1]) begin
      rem_nxt = trial[DW-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DW-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[W-1] ? (~dividend + W'(1)) : dividend;
      rem_r <= '0;
      d_r   <= divisor;
      neg_r <= dividend[W-1];
    end else if (step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = neg_r ? $signed(~quo_r + W'(1)) : $signed(quo_r);

endmodule

// ----- rtl/core/scbs_dp.sv -----
// datapath: gain and clip, 0.95 scale, history rings, running sum, dividers
module scbs_dp #(
  parameter int MAX_TAPS    = 32,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [scbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]       left_sample,
  input  logic signed [SAMPLE_BITS-1:0]       right_sample,
  input  logic                                block_last,
  input  scbs_pkg::scbs_cmd_t                 cmd,
  output scbs_pkg::scbs_sts_t                 sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       left_out,
  output logic signed [SAMPLE_BITS-1:0]       right_out,
  output logic                                block_last_out
);

  localparam int SB    = SAMPLE_BITS;
  localparam int LEN_W = $clog2(MAX_TAPS + 1);
  localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int MW    = SB + scbs_pkg::GAIN_W + 1;
  localparam int PW    = SB + 16;
  localparam int SUM_W = SB + LEN_W;

  localparam logic signed [MW-1:0] CLIP_HI = {{(MW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [MW-1:0] CLIP_LO = {{(MW-SB+1){1'b1}}, {(SB-1){1'b0}}};

  // configuration
  logic [scbs_pkg::GAIN_W-1:0] gain_r;
  logic [scbs_pkg::TONE_W-1:0] tone_r;
  logic [LEN_W-1:0]            len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
      tone_r <= scbs_pkg::TONE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        scbs_pkg::CFG_IDX_GAIN: gain_r <= cfg_data[scbs_pkg::GAIN_W-1:0];
        scbs_pkg::CFG_IDX_TONE: tone_r <= cfg_data[scbs_pkg::TONE_W-1:0];
        default: ;
      endcase
    end
  end

  assign len = (32'(tone_r) > MAX_TAPS) ? LEN_W'(MAX_TAPS) : LEN_W'(tone_r);

  // shaping pipe
  logic signed [SB-1:0] in_l_r, in_r_r;
  logic                 last_r;
  logic signed [MW-1:0] prod_l_r, prod_r_r;
  logic signed [SB-1:0] clip_l, clip_r;
  logic signed [PW-1:0] scl_l_r, scl_r_r;
  logic signed [SB-1:0] y_l, y_r;

  always_comb begin
    if (prod_l_r > CLIP_HI)      clip_l = CLIP_HI[SB-1:0];
    else if (prod_l_r < CLIP_LO) clip_l = CLIP_LO[SB-1:0];
    else                         clip_l = prod_l_r[SB-1:0];
    if (prod_r_r > CLIP_HI)      clip_r = CLIP_HI[SB-1:0];
    else if (prod_r_r < CLIP_LO) clip_r = CLIP_LO[SB-1:0];
    else                         clip_r = prod_r_r[SB-1:0];
  end

  // arithmetic shift, rounds toward minus infinity
  assign y_l = scl_l_r[SB+scbs_pkg::SCALE_SHIFT-1:scbs_pkg::SCALE_SHIFT];
  assign y_r = scl_r_r[SB+scbs_pkg::SCALE_SHIFT-1:scbs_pkg::SCALE_SHIFT];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_l_r <= left_sample;
      in_r_r <= right_sample;
      last_r <= block_last;
    end
    if (cmd.mul) begin
      prod_l_r <= in_l_r * $signed({1'b0, gain_r});
      prod_r_r <= in_r_r * $signed({1'b0, gain_r});
    end
    if (cmd.scale) begin
      scl_l_r <= clip_l * scbs_pkg::SCALE_NUM;
      scl_r_r <= clip_r * scbs_pkg::SCALE_NUM;
    end
  end

  // history rings, left and right side by side in one memory
  logic [2*SB-1:0]     ring_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0] vld_r;
  logic [LEN_W-1:0]    pos_r;
  logic [LEN_W-1:0]    wr_idx;
  logic [LEN_W-1:0]    rd_idx_r;
  logic [2*SB-1:0]     rd_data_r;
  logic                rd_vld_r;
  logic                pend_r;

  assign wr_idx = (pos_r >= len) ? '0 : pos_r;

  always_ff @(posedge clk) begin
    if (cmd.ring_wr) begin
      ring_mem[wr_idx[IDX_W-1:0]] <= {y_l, y_r};
    end
    if (cmd.sum_rd) begin
      rd_data_r <= ring_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      pos_r    <= '0;
      rd_idx_r <= '0;
      pend_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.ring_wr) begin
        vld_r[wr_idx[IDX_W-1:0]] <= 1'b1;
        pos_r <= wr_idx + LEN_W'(1);
      end
      if (cmd.sum_clr) begin
        rd_idx_r <= '0;
      end else if (cmd.sum_rd) begin
        rd_idx_r <= rd_idx_r + LEN_W'(1);
      end
      pend_r <= cmd.sum_rd;
      if (cmd.sum_rd) begin
        rd_vld_r <= vld_r[rd_idx_r[IDX_W-1:0]];
      end
    end
  end

  // running sums, one entry per cycle
  logic signed [SUM_W-1:0] sum_l_r, sum_r_r;
  logic signed [SB-1:0]    rd_l, rd_r;

  assign rd_l = rd_vld_r ? rd_data_r[2*SB-1:SB] : '0;
  assign rd_r = rd_vld_r ? rd_data_r[SB-1:0]    : '0;

  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      sum_l_r <= '0;
      sum_r_r <= '0;
    end else if (pend_r) begin
      sum_l_r <= sum_l_r + {{LEN_W{rd_l[SB-1]}}, rd_l};
      sum_r_r <= sum_r_r + {{LEN_W{rd_r[SB-1]}}, rd_r};
    end
  end

  // dividers
  logic signed [SUM_W-1:0] q_l, q_r;
  logic                    last_l, last_rt;

  scbs_div #(.W(SUM_W), .DW(LEN_W)) u_div_l (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (sum_l_r),
    .divisor  (len),
    .quotient (q_l),
    .last     (last_l)
  );

  scbs_div #(.W(SUM_W), .DW(LEN_W)) u_div_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (sum_r_r),
    .divisor  (len),
    .quotient (q_r),
    .last     (last_rt)
  );

  // output register
  logic                 out_valid_r;
  logic signed [SB-1:0] out_l_r, out_r_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_l_r    <= sts.bypass ? y_l : q_l[SB-1:0];
      out_r_r    <= sts.bypass ? y_r : q_r[SB-1:0];
      out_last_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign left_out       = out_l_r;
  assign right_out      = out_r_r;
  assign block_last_out = out_last_r;

  assign sts.bypass   = (len == '0);
  assign sts.rd_last  = (rd_idx_r == len - LEN_W'(1));
  assign sts.div_last = last_l & last_rt;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

// ----- rtl/core/scbs_ctrl.sv -----
// controller: sequences one frame through shaping and, unless bypassed, ring update, sum and divide
module scbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  scbs_pkg::scbs_sts_t sts,
  output scbs_pkg::scbs_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_DIVL,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.sum_clr = 1'b1;
        cmd.ring_wr = !sts.bypass;
        state_nxt   = sts.bypass ? ST_OUT : ST_READ;
      end
      ST_READ: begin
        cmd.sum_rd = 1'b1;
        if (sts.rd_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DIVL;
      end
      ST_DIVL: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/stereo_clip_boxcar_smoother.sv -----
// top level of the stereo hard-clip distortion with boxcar smoother
// Each stereo frame is multiplied by the integer gain, clipped to [-1, 1) and
// scaled by 0.95 (31130/32768, arithmetic shift). With tone_length 0 the
// scaled pair is loaded into the output register once that is free, and the
// block returns to idle for the next frame. Otherwise the pair is written into
// per-channel history rings and the output is the sum of the first
// tone_length entries divided by tone_length, truncated toward zero. One
// frame is in flight at a time; the result is loaded into the output register
// after the window walk and the division, and the block then returns to idle
// for the next frame. The ring memory has one read port, so the sum walks the
// window one entry per cycle, and the two dividers retire one quotient bit per
// cycle over the SAMPLE_BITS + clog2(MAX_TAPS+1) bits of the sum. A finished
// result waits in the output register while the next frame is accepted.
// History valid bits are cleared at reset, so no clearing pass is needed.
// Configuration is written through cfg_we, cfg_index and cfg_data (index 0
// gain, index 1 tone_length); the user must do so only while the block is
// idle, as the block itself does not enforce this.
module stereo_clip_boxcar_smoother #(
  parameter int MAX_TAPS    = 32,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [scbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scbs_pkg::CFG_DATA_W-1:0] cfg_data,
  // frame transactions in and results out
  scbs_in_if.sink                         in_if,
  scbs_out_if.source                      out_if
);

  scbs_pkg::scbs_cmd_t cmd;
  scbs_pkg::scbs_sts_t sts;

  // sequencing of shaping, ring write, window walk and division
  scbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // all arithmetic, storage and the output register
  scbs_dp #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .left_sample    (in_if.left_sample),
    .right_sample   (in_if.right_sample),
    .block_last     (in_if.block_last),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .left_out       (out_if.left_out),
    .right_out      (out_if.right_out),
    .block_last_out (out_if.block_last_out)
  );

endmodule
